/* hdl/urf_pkg.sv */
// Shared constants, types and helpers of the unsigned radix ASCII formatter.
`default_nettype none
package urf_pkg;

   localparam int VALUE_BITS     = 64;
   localparam int MAX_MIN_DIGITS = 64;

   // Field widths of the channels.
   localparam int VALUE_W = 64;
   localparam int TYPE_W  = 2;
   localparam int MIN_W   = 7;
   localparam int CHAR_W  = 8;

   // Double dabble runs two bits per cycle, so the binary word is padded to even width.
   localparam int DD_BITS    = VALUE_BITS + (VALUE_BITS % 2);
   localparam int DD_ITERS   = DD_BITS / 2;
   localparam int ITER_W     = $clog2(DD_ITERS + 1);
   // Decimal digits needed for VALUE_BITS bits: floor(n * log10(2)) + 1.
   localparam int BCD_DIGITS = (VALUE_BITS * 301) / 1000 + 1;
   localparam int WORK_W     = 4 * BCD_DIGITS;
   // Octal gives the most digits.
   localparam int STORE_DEPTH = (VALUE_BITS + 2) / 3;
   localparam int IDX_W       = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int PAD_W       = $clog2(MAX_MIN_DIGITS + 1);

   localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'd48;
   localparam logic [CHAR_W-1:0] HEX_UPPER_OFS = 8'd7;
   localparam logic [CHAR_W-1:0] HEX_LOWER_OFS = 8'd39;
   localparam logic [3:0]        DIGIT_NINE    = 4'd9;

   typedef enum logic [TYPE_W-1:0] {
      FMT_DEC    = 2'd0,
      FMT_OCT    = 2'd1,
      FMT_HEX_LO = 2'd2,
      FMT_HEX_UP = 2'd3
   } fmt_type;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_DABBLE  = 4'b0010,
      ST_EXTRACT = 4'b0100,
      ST_EMIT    = 4'b1000
   } state_type;

   // One character request from the sequencer to the output stage.
   typedef struct packed {
      logic       is_pad;
      logic [3:0] digit;
      logic       upper;
      logic       last;
   } emit_type;

   function automatic logic [CHAR_W-1:0] digit_ascii(input logic [3:0] d, input logic upper);
      logic [CHAR_W-1:0] wide;
      wide = {4'd0, d};
      if (d <= DIGIT_NINE) begin
         return ASCII_ZERO + wide;
      end else if (upper) begin
         return ASCII_ZERO + HEX_UPPER_OFS + wide;
      end
      return ASCII_ZERO + HEX_LOWER_OFS + wide;
   endfunction

endpackage
`default_nettype wire

/* hdl/urf_req_if.sv */
// Request channel: number and format of one conversion.
`default_nettype none
interface urf_req_if;
   import urf_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;
   logic [TYPE_W-1:0]  req_type;
   logic [MIN_W-1:0]   min_digits;
   logic               octal_alt_form;

   modport source (output valid, value, req_type, min_digits, octal_alt_form, input ready);
   modport sink   (input valid, value, req_type, min_digits, octal_alt_form, output ready);
endinterface
`default_nettype wire

/* hdl/urf_rsp_if.sv */
// Response channel: one ASCII character per transfer.
`default_nettype none
interface urf_rsp_if;
   import urf_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              last_char;

   modport source (output valid, char_code, last_char, input ready);
   modport sink   (input valid, char_code, last_char, output ready);
endinterface
`default_nettype wire

/* hdl/urf_shift_unit.sv */
// Shared shift datapath: double dabble step pair and radix digit extraction.
`default_nettype none
module urf_shift_unit (
   input  wire logic [urf_pkg::WORK_W-1:0]  work_in,
   input  wire logic [urf_pkg::DD_BITS-1:0] bin_in,
   input  wire logic                        octal,
   output logic      [urf_pkg::WORK_W-1:0]  dab_work,
   output logic      [urf_pkg::DD_BITS-1:0] dab_bin,
   output logic      [urf_pkg::WORK_W-1:0]  ext_work,
   output logic      [3:0]                  ext_digit
);
   import urf_pkg::*;

   // Two add-3/shift steps per call.
   always_comb begin
      logic [WORK_W-1:0]  w;
      logic [DD_BITS-1:0] b;
      w = work_in;
      b = bin_in;
      for (int s = 0; s < 2; s++) begin
         for (int k = 0; k < BCD_DIGITS; k++) begin
            if (w[4*k +: 4] >= 4'd5) begin
               w[4*k +: 4] = w[4*k +: 4] + 4'd3;
            end
         end
         w = {w[WORK_W-2:0], b[DD_BITS-1]};
         b = {b[DD_BITS-2:0], 1'b0};
      end
      dab_work = w;
      dab_bin  = b;
   end

   always_comb begin
      if (octal) begin
         ext_digit = {1'b0, work_in[2:0]};
         ext_work  = work_in >> 3;
      end else begin
         ext_digit = work_in[3:0];
         ext_work  = work_in >> 4;
      end
   end
endmodule
`default_nettype wire

/* hdl/urf_char_out.sv */
// Output register stage: turns digit requests into ASCII response transfers.
`default_nettype none
module urf_char_out (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              emit_valid,
   input  wire urf_pkg::emit_type emit_data,
   output logic                   emit_ready,
   urf_rsp_if.source              rsp_chan
);
   import urf_pkg::*;

   logic              valid_ff, valid_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              last_ff, last_in;

   assign emit_ready = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (emit_ready) begin
         valid_in = emit_valid;
         if (emit_valid) begin
            char_in = emit_data.is_pad ? ASCII_ZERO
                                       : digit_ascii(emit_data.digit, emit_data.upper);
            last_in = emit_data.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.char_code = char_ff;
   assign rsp_chan.last_char = last_ff;
endmodule
`default_nettype wire

/* hdl/unsigned_radix_ascii_formatter_unit.sv */
// Top level of the unsigned radix ASCII formatter: sequencer, digit store and channels.
//
//  channel   dir  transfer moves
//  req_chan  in   value, req_type, min_digits, octal_alt_form (one number)
//  rsp_chan  out  char_code, last_char (one character, most significant first)
//
// Conversion runs through the shared shift unit after the number is accepted:
//   decimal  DD_ITERS (32) double dabble iterations, then digit extraction (up to 20),
//   octal    digit extraction (up to 22), hex digit extraction (up to 16).
// Then every character (pads plus digits) goes out through the output register.
// req_chan.ready is high only while the sequencer is idle; a stalled response
// freezes character emission, the last character may still wait when the next
// number is accepted. Reset clears the sequencer and the response valid.
`default_nettype none
module unsigned_radix_ascii_formatter_unit (
   input  wire logic clock,
   input  wire logic reset,
   urf_req_if.sink   req_chan,
   urf_rsp_if.source rsp_chan
);
   import urf_pkg::*;

   state_type          state_ff, state_in;
   logic [WORK_W-1:0]  work_ff, work_in;
   logic [DD_BITS-1:0] bin_ff, bin_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PAD_W-1:0]   pad_ff, pad_in;
   logic [PAD_W-1:0]   min_ff, min_in;
   fmt_type            fmt_ff, fmt_in;
   logic               alt_ff, alt_in;

   // Digits, least significant first; entries are written before being read.
   logic [3:0]         store_ff [STORE_DEPTH];
   logic               store_we;

   logic [WORK_W-1:0]  dab_work, ext_work;
   logic [DD_BITS-1:0] dab_bin;
   logic [3:0]         ext_digit;

   logic               emit_valid, emit_ready;
   emit_type           emit_data;

   logic               req_xfer;
   logic [CNT_W-1:0]   count_next;
   logic [PAD_W-1:0]   count_wide;
   logic [CNT_W-1:0]   read_cnt;

   urf_shift_unit u_shift (
      .work_in   (work_ff),
      .bin_in    (bin_ff),
      .octal     (fmt_ff == FMT_OCT),
      .dab_work  (dab_work),
      .dab_bin   (dab_bin),
      .ext_work  (ext_work),
      .ext_digit (ext_digit)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;

   assign count_next = count_ff + CNT_W'(1);
   assign count_wide = PAD_W'(count_next);
   assign read_cnt   = count_ff - CNT_W'(1);

   // Next character: pad zeros first, then stored digits from the top.
   assign emit_valid       = (state_ff == ST_EMIT);
   assign emit_data.is_pad = (pad_ff != '0);
   assign emit_data.digit  = store_ff[read_cnt[IDX_W-1:0]];
   assign emit_data.upper  = (fmt_ff == FMT_HEX_UP);
   assign emit_data.last   = (pad_ff == '0) && (count_ff == CNT_W'(1));

   always_comb begin
      state_in = state_ff;
      work_in  = work_ff;
      bin_in   = bin_ff;
      iter_in  = iter_ff;
      count_in = count_ff;
      pad_in   = pad_ff;
      min_in   = min_ff;
      fmt_in   = fmt_ff;
      alt_in   = alt_ff;
      store_we = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               fmt_in   = fmt_type'(req_chan.req_type);
               alt_in   = req_chan.octal_alt_form;
               min_in   = (req_chan.min_digits > MIN_W'(MAX_MIN_DIGITS))
                          ? PAD_W'(MAX_MIN_DIGITS) : PAD_W'(req_chan.min_digits);
               count_in = '0;
               pad_in   = '0;
               if (fmt_type'(req_chan.req_type) == FMT_DEC) begin
                  work_in  = '0;
                  bin_in   = DD_BITS'(req_chan.value[VALUE_BITS-1:0]);
                  iter_in  = ITER_W'(DD_ITERS);
                  state_in = ST_DABBLE;
               end else begin
                  work_in  = WORK_W'(req_chan.value[VALUE_BITS-1:0]);
                  state_in = ST_EXTRACT;
               end
            end
         end
         ST_DABBLE: begin
            work_in = dab_work;
            bin_in  = dab_bin;
            iter_in = iter_ff - ITER_W'(1);
            if (iter_ff == ITER_W'(1)) begin
               state_in = ST_EXTRACT;
            end
         end
         ST_EXTRACT: begin
            // Do-while: at least one digit, stop once the remainder is zero.
            store_we = 1'b1;
            work_in  = ext_work;
            count_in = count_next;
            if (ext_work == '0) begin
               if (count_wide < min_ff) begin
                  pad_in = min_ff - count_wide
                           - PAD_W'((fmt_ff == FMT_OCT) && alt_ff);
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_ready) begin
               if (pad_ff != '0) begin
                  pad_in = pad_ff - PAD_W'(1);
               end else begin
                  count_in = read_cnt;
                  if (count_ff == CNT_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pad_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pad_ff   <= pad_in;
      end
      work_ff <= work_in;
      bin_ff  <= bin_in;
      iter_ff <= iter_in;
      min_ff  <= min_in;
      fmt_ff  <= fmt_in;
      alt_ff  <= alt_in;
      if (store_we) begin
         store_ff[count_ff[IDX_W-1:0]] <= ext_digit;
      end
   end

   urf_char_out u_out (
      .clock      (clock),
      .reset      (reset),
      .emit_valid (emit_valid),
      .emit_data  (emit_data),
      .emit_ready (emit_ready),
      .rsp_chan   (rsp_chan)
   );

   // A number leaves the idle state right after its transfer.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_chan.ready)
      else $error("sequencer still ready after request transfer");

   // Extraction never writes past the digit store.
   a_store_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXTRACT) |-> (count_ff < CNT_W'(STORE_DEPTH)))
      else $error("digit store overflow");

   // While emitting, at least one digit is left behind any pad zero.
   a_digits_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (count_ff != '0))
      else $error("emitting with empty digit store");

   // The dabble counter is live for every dabble cycle.
   a_iter_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DABBLE) |-> (iter_ff != '0))
      else $error("dabble counter ran out");

endmodule
`default_nettype wire
